// ----- rtl/assert_macros.svh -----
// Assertion helpers for the timer scheduler checker.
// Both expect signals named clk and arst_n in the scope of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define MTES_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define MTES_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/mtes_pkg.sv -----
`timescale 1ns / 1ps
package mtes_pkg;

	localparam int NUM_TIMERS = 16;
	localparam int TIME_BITS  = 48;
	localparam int IDX_W      = 4;
	localparam int AMOUNT_W   = 32;
	localparam int PARAM_W    = 32;
	localparam int SLICE_W    = 20;
	localparam int CELL_IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
	localparam int CMP_W      = (CELL_IDX_W > IDX_W) ? CELL_IDX_W : IDX_W;

	localparam logic [SLICE_W-1:0]   SLICE_CAP_RESET = SLICE_W'(100000);
	localparam logic [TIME_BITS-1:0] TIME_MAX        = {TIME_BITS{1'b1}};

	localparam logic MODE_ARM     = 1'b0;
	localparam logic MODE_ADVANCE = 1'b1;
	localparam logic KIND_FIRE    = 1'b0;
	localparam logic KIND_SUMMARY = 1'b1;

	typedef logic [TIME_BITS-1:0] time_t;

	// Running minimum carried down the row of timer cells
	typedef struct packed {
		logic                  valid;
		logic                  found;
		logic [CELL_IDX_W-1:0] idx;
		time_t                 expiry;
		logic [PARAM_W-1:0]    param;
	} cand_t;

	// Write or disable request broadcast to the cells
	typedef struct packed {
		logic               valid;
		logic               arm;
		logic [CMP_W-1:0]   idx;
		logic               enable;
		time_t              expiry;
		logic [PARAM_W-1:0] param;
	} cmd_t;

	typedef struct packed {
		logic               kind;
		logic [IDX_W-1:0]   fired_index;
		logic [PARAM_W-1:0] fired_param;
		time_t              fired_time;
		time_t              next_expiry;
		logic               none_pending;
		logic [SLICE_W-1:0] slice_length;
		logic               last;
	} out_t;

	// Saturating time plus duration
	function automatic time_t sat_add(input time_t a, input logic [AMOUNT_W-1:0] b);
		logic [TIME_BITS:0] s;
		s = {1'b0, a} + (TIME_BITS+1)'(b);
		return s[TIME_BITS] ? TIME_MAX : s[TIME_BITS-1:0];
	endfunction

endpackage

// ----- rtl/mtes_req_if.sv -----
`timescale 1ns / 1ps
interface mtes_req_if import mtes_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic                      mode;
	logic [IDX_W-1:0]          timer_index;
	logic [AMOUNT_W-1:0]       amount;
	logic                      never_flag;
	logic                      from_fire_time;
	logic signed [PARAM_W-1:0] param;

	modport source(output valid, mode, timer_index, amount, never_flag, from_fire_time,
		param, input ready);
	modport sink(input valid, mode, timer_index, amount, never_flag, from_fire_time,
		param, output ready);
endinterface

// ----- rtl/mtes_rsp_if.sv -----
`timescale 1ns / 1ps
interface mtes_rsp_if import mtes_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic                      kind;
	logic [IDX_W-1:0]          fired_index;
	logic signed [PARAM_W-1:0] fired_param;
	logic [TIME_BITS-1:0]      fired_time;
	logic [TIME_BITS-1:0]      next_expiry;
	logic                      none_pending;
	logic [SLICE_W-1:0]        slice_length;
	logic                      last;

	modport source(output valid, kind, fired_index, fired_param, fired_time, next_expiry,
		none_pending, slice_length, last, input ready);
	modport sink(input valid, kind, fired_index, fired_param, fired_time, next_expiry,
		none_pending, slice_length, last, output ready);
endinterface

// ----- rtl/mtes_cfg_if.sv -----
`timescale 1ns / 1ps
interface mtes_cfg_if import mtes_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [SLICE_W-1:0] data;

	modport source(output valid, data, input ready);
	modport sink(input valid, data, output ready);
endinterface

// ----- rtl/mtes_cell.sv -----
`timescale 1ns / 1ps
module mtes_cell import mtes_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [CELL_IDX_W-1:0] my_idx,
	input  cmd_t                  cmd,
	input  cand_t                 cand_in,
	output cand_t                 cand_out
);

	logic               en_q;
	time_t              exp_q;
	logic [PARAM_W-1:0] par_q;
	logic               vld_q;
	logic               found_q;
	logic [CELL_IDX_W-1:0] idx_q;
	time_t              cexp_q;
	logic [PARAM_W-1:0] cpar_q;
	logic               hit;
	logic               take;

	assign hit  = cmd.valid && (cmd.idx == CMP_W'(my_idx));
	// Claim the running minimum when strictly earlier; ties stay with the lower index
	assign take = en_q && (!cand_in.found || exp_q < cand_in.expiry);

	// Hold enable and pass the scan token along
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_q  <= 1'b0;
			vld_q <= 1'b0;
		end else begin
			vld_q <= cand_in.valid;
			if (hit) begin
				en_q <= cmd.enable;
			end
		end
	end

	// Store timer payload and forward the candidate
	always_ff @(posedge clk) begin
		if (hit && cmd.arm) begin
			exp_q <= cmd.expiry;
			par_q <= cmd.param;
		end
		if (take) begin
			found_q <= 1'b1;
			idx_q   <= my_idx;
			cexp_q  <= exp_q;
			cpar_q  <= par_q;
		end else begin
			found_q <= cand_in.found;
			idx_q   <= cand_in.idx;
			cexp_q  <= cand_in.expiry;
			cpar_q  <= cand_in.param;
		end
	end

	assign cand_out = '{valid: vld_q, found: found_q, idx: idx_q, expiry: cexp_q,
		param: cpar_q};

endmodule

// ----- rtl/mtes_ctrl.sv -----
`timescale 1ns / 1ps
module mtes_ctrl import mtes_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	mtes_req_if.sink   req,
	mtes_rsp_if.source rsp,
	mtes_cfg_if.sink   cfg,
	output cmd_t       cmd,
	output cand_t      head,
	input  cand_t      tail
);

	typedef enum logic [1:0] {ST_IDLE, ST_INJECT, ST_SCAN, ST_EMIT} state_t;

	state_t             state_q;
	time_t              base_q;
	time_t              last_fire_q;
	logic [SLICE_W-1:0] slice_cap_q;
	cand_t              res_q;
	out_t               out_q;
	logic               out_vld_q;

	logic               accept;
	logic               emit_go;
	logic               is_due;
	time_t              now;
	time_t              diff;
	time_t              diff_min1;
	logic [SLICE_W-1:0] lim;
	logic [SLICE_W-1:0] slice;
	out_t               out_d;

	assign req.ready = (state_q == ST_IDLE);
	assign cfg.ready = 1'b1;
	assign accept    = req.valid && req.ready;
	assign emit_go   = (state_q == ST_EMIT) && (!out_vld_q || rsp.ready);
	assign is_due    = res_q.found && (res_q.expiry <= base_q);
	assign now       = req.from_fire_time ? last_fire_q : base_q;

	// Start a scan with an empty candidate
	assign head = '{valid: (state_q == ST_INJECT), found: 1'b0, idx: '0, expiry: '0,
		param: '0};

	// Arm on accept, disable the fired timer on emit
	always_comb begin
		cmd = '0;
		if (accept && req.mode == MODE_ARM) begin
			cmd.valid  = 1'b1;
			cmd.arm    = 1'b1;
			cmd.idx    = CMP_W'(req.timer_index);
			cmd.enable = !req.never_flag;
			cmd.expiry = req.never_flag ? TIME_MAX : sat_add(now, req.amount);
			cmd.param  = req.param;
		end else if (emit_go && is_due) begin
			cmd.valid = 1'b1;
			cmd.idx   = CMP_W'(res_q.idx);
		end
	end

	// Slice length: clamp(next - base, 1, slice cap), the cap alone when none pending; a zero cap counts as 1
	assign lim       = (slice_cap_q == '0) ? SLICE_W'(1) : slice_cap_q;
	assign diff      = (res_q.expiry > base_q) ? res_q.expiry - base_q : '0;
	assign diff_min1 = (diff == '0) ? TIME_BITS'(1) : diff;
	always_comb begin
		if (!res_q.found) begin
			slice = lim;
		end else if (diff_min1 < TIME_BITS'(lim)) begin
			slice = SLICE_W'(diff_min1);
		end else begin
			slice = lim;
		end
	end

	// Build the next result: a firing when the minimum is due, else the summary
	always_comb begin
		out_d = '0;
		if (is_due) begin
			out_d.kind        = KIND_FIRE;
			out_d.fired_index = IDX_W'(res_q.idx);
			out_d.fired_param = res_q.param;
			out_d.fired_time  = res_q.expiry;
		end else begin
			out_d.kind         = KIND_SUMMARY;
			out_d.next_expiry  = res_q.found ? res_q.expiry : '0;
			out_d.none_pending = !res_q.found;
			out_d.slice_length = slice;
			out_d.last         = 1'b1;
		end
	end

	// Sequencer and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			base_q      <= '0;
			last_fire_q <= '0;
			slice_cap_q <= SLICE_CAP_RESET;
			res_q       <= '0;
			out_q       <= '0;
			out_vld_q   <= 1'b0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				slice_cap_q <= cfg.data;
			end
			// Hold the result until taken
			if (emit_go) begin
				out_vld_q <= 1'b1;
			end else if (rsp.ready) begin
				out_vld_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept && req.mode == MODE_ADVANCE) begin
						base_q  <= sat_add(base_q, req.amount);
						state_q <= ST_INJECT;
					end
				end
				ST_INJECT: begin
					state_q <= ST_SCAN;
				end
				ST_SCAN: begin
					if (tail.valid) begin
						res_q   <= tail;
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (emit_go) begin
						out_q <= out_d;
						if (is_due) begin
							last_fire_q <= res_q.expiry;
							state_q     <= ST_INJECT;
						end else begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign rsp.valid        = out_vld_q;
	assign rsp.kind         = out_q.kind;
	assign rsp.fired_index  = out_q.fired_index;
	assign rsp.fired_param  = out_q.fired_param;
	assign rsp.fired_time   = out_q.fired_time;
	assign rsp.next_expiry  = out_q.next_expiry;
	assign rsp.none_pending = out_q.none_pending;
	assign rsp.slice_length = out_q.slice_length;
	assign rsp.last         = out_q.last;

endmodule

// ----- rtl/multi_timer_expiry_scheduler_core.sv -----
`timescale 1ns / 1ps
// Arm item: taken while idle and leaves the block idle; the next item is taken in the following cycle.
// Advance item: each result (firing or summary) comes from a scan through ST_INJECT, ST_SCAN and ST_EMIT,
// with the scan token walking the row of timer cells, one cell per cycle.
// An advance that fires k timers holds the input off for k + 1 scans,
// longer while the result side holds off.
// Reset (async, active low): all timers disabled, times zero, slice cap 100000.
module multi_timer_expiry_scheduler_core import mtes_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	mtes_cfg_if.sink   cfg,
	mtes_req_if.sink   req,
	mtes_rsp_if.source rsp
);

	cmd_t  cmd;
	cand_t chain [NUM_TIMERS+1];

	mtes_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp),
		.cfg    (cfg),
		.cmd    (cmd),
		.head   (chain[0]),
		.tail   (chain[NUM_TIMERS])
	);

	// Row of timer cells, one per timer
	for (genvar i = 0; i < NUM_TIMERS; i++) begin : g_cell
		mtes_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.my_idx   (CELL_IDX_W'(i)),
			.cmd      (cmd),
			.cand_in  (chain[i]),
			.cand_out (chain[i+1])
		);
	end

endmodule

// ----- rtl/mtes_checker.sv -----
`timescale 1ns / 1ps
`include "assert_macros.svh"
module mtes_checker import mtes_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               rsp_valid,
	input logic               rsp_ready,
	input logic               rsp_kind,
	input logic               rsp_last,
	input logic               rsp_none_pending,
	input logic [TIME_BITS-1:0] rsp_next_expiry,
	input logic [SLICE_W-1:0] rsp_slice_length
);

	`MTES_ASSERT_IMP(a_summary_last, rsp_valid && rsp_kind == KIND_SUMMARY, rsp_last, "summary not last")
	`MTES_ASSERT_IMP(a_fire_clean, rsp_valid && rsp_kind == KIND_FIRE, !rsp_last && !rsp_none_pending, "firing item marked last or idle")
	`MTES_ASSERT_IMP(a_slice_nonzero, rsp_valid && rsp_kind == KIND_SUMMARY, rsp_slice_length != '0, "zero slice length")
	`MTES_ASSERT_IMP(a_idle_no_expiry, rsp_valid && rsp_none_pending, rsp_next_expiry == '0, "expiry given with none pending")
	`MTES_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid, "result dropped while stalled")

endmodule

bind multi_timer_expiry_scheduler_core mtes_checker u_mtes_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.rsp_valid        (rsp.valid),
	.rsp_ready        (rsp.ready),
	.rsp_kind         (rsp.kind),
	.rsp_last         (rsp.last),
	.rsp_none_pending (rsp.none_pending),
	.rsp_next_expiry  (rsp.next_expiry),
	.rsp_slice_length (rsp.slice_length)
);

// ----- test/tb_multi_timer_expiry_scheduler_core.sv -----
`timescale 1ns / 1ps
module tb_multi_timer_expiry_scheduler_core;
	import mtes_pkg::*;

	localparam int RESET_CYCLES = 9;
	localparam int GAP_MAX      = 17;
	localparam int SCAN_CYCLES  = NUM_TIMERS + 2;
	localparam int CYCLE_LIMIT  = 1000000;
	localparam int REPORT_LINES = 40;
	localparam int PHASE_ITEMS  = 35;

	typedef struct {
		logic                 mode;
		logic [IDX_W-1:0]     idx;
		logic [AMOUNT_W-1:0]  amount;
		logic                 never;
		logic                 from_fire;
		logic [PARAM_W-1:0]   param;
	} timer_cmd_t;

	logic clk;
	logic arst_n;

	mtes_cfg_if cfg_if ();
	mtes_req_if req_if ();
	mtes_rsp_if rsp_if ();

	multi_timer_expiry_scheduler_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_if),
		.req    (req_if),
		.rsp    (rsp_if)
	);

	// Scheduler state as the testbench sees it
	logic               tmr_on  [NUM_TIMERS];
	time_t              tmr_due [NUM_TIMERS];
	logic [PARAM_W-1:0] tmr_arg [NUM_TIMERS];
	time_t              clock_now;
	time_t              last_fired;
	logic [SLICE_W-1:0] slice_cap;
	out_t               firing_q[$];

	int error_count   = 0;
	int cycle_count   = 0;
	int rsp_gap_left  = 0;
	int rsp_hold_left = 0;
	bit req_calm      = 0;
	bit rsp_calm      = 0;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Saturate at the all-ones time
	function automatic time_t add_sat(input time_t a, input logic [AMOUNT_W-1:0] b);
		time_t room;
		room = TIME_MAX - a;
		if (time_t'(b) > room)
			return TIME_MAX;
		return a + time_t'(b);
	endfunction

	function automatic int draw_gap(input bit calm);
		if (calm || $urandom_range(0, 1) == 0)
			return 0;
		return $urandom_range(0, GAP_MAX);
	endfunction

	function automatic void clear_schedule();
		int i;
		for (i = 0; i < NUM_TIMERS; i++) begin
			tmr_on[i]  = 1'b0;
			tmr_due[i] = '0;
			tmr_arg[i] = '0;
		end
		clock_now  = '0;
		last_fired = '0;
		slice_cap  = SLICE_CAP_RESET;
	endfunction

	// Update the schedule for one accepted item and queue the results it causes
	function automatic void schedule_cmd(input timer_cmd_t c);
		int                 i;
		int                 pick;
		logic               any;
		time_t              soonest;
		time_t              span;
		logic [SLICE_W-1:0] cap;
		out_t               r;
		if (c.mode == MODE_ARM) begin
			if (c.idx < NUM_TIMERS) begin
				tmr_arg[c.idx] = c.param;
				if (c.never) begin
					tmr_on[c.idx]  = 1'b0;
					tmr_due[c.idx] = TIME_MAX;
				end else begin
					tmr_on[c.idx]  = 1'b1;
					tmr_due[c.idx] = add_sat(c.from_fire ? last_fired : clock_now, c.amount);
				end
			end
			return;
		end
		clock_now = add_sat(clock_now, c.amount);
		// Fire due timers, earliest first, lower index on ties
		forever begin
			pick = -1;
			for (i = 0; i < NUM_TIMERS; i++) begin
				if (tmr_on[i] && tmr_due[i] <= clock_now &&
					(pick < 0 || tmr_due[i] < tmr_due[pick]))
					pick = i;
			end
			if (pick < 0)
				break;
			tmr_on[pick]  = 1'b0;
			last_fired    = tmr_due[pick];
			tmr_due[pick] = TIME_MAX;
			r             = '0;
			r.kind        = KIND_FIRE;
			r.fired_index = IDX_W'(pick);
			r.fired_param = tmr_arg[pick];
			r.fired_time  = last_fired;
			firing_q      = {firing_q, r};
		end
		// Close with the summary
		any     = 1'b0;
		soonest = '0;
		for (i = 0; i < NUM_TIMERS; i++) begin
			if (tmr_on[i] && (!any || tmr_due[i] < soonest)) begin
				soonest = tmr_due[i];
				any     = 1'b1;
			end
		end
		cap            = (slice_cap == '0) ? SLICE_W'(1) : slice_cap;
		r              = '0;
		r.kind         = KIND_SUMMARY;
		r.none_pending = !any;
		r.slice_length = cap;
		r.last         = 1'b1;
		if (any) begin
			span = (soonest > clock_now) ? soonest - clock_now : '0;
			if (span < 1)
				span = 1;
			if (span < time_t'(cap))
				r.slice_length = span[SLICE_W-1:0];
			r.next_expiry = soonest;
		end
		firing_q = {firing_q, r};
	endfunction

	task automatic report_mismatch(input string what, input logic [63:0] got,
		input logic [63:0] want);
		error_count++;
		if (error_count <= REPORT_LINES)
			$display("%0t: mismatch on %s: got %0h, want %0h", $time, what, got, want);
	endtask

	task automatic check_field(input string name, input logic [63:0] got,
		input logic [63:0] want);
		if (got !== want)
			report_mismatch(name, got, want);
	endtask

	// Check results, then track accepted items and register writes
	always @(posedge clk) begin : monitor
		out_t       got;
		out_t       want;
		timer_cmd_t c;
		if (arst_n) begin
			if (rsp_if.valid && rsp_if.ready) begin
				rsp_gap_left     = draw_gap(rsp_calm);
				got.kind         = rsp_if.kind;
				got.fired_index  = rsp_if.fired_index;
				got.fired_param  = rsp_if.fired_param;
				got.fired_time   = rsp_if.fired_time;
				got.next_expiry  = rsp_if.next_expiry;
				got.none_pending = rsp_if.none_pending;
				got.slice_length = rsp_if.slice_length;
				got.last         = rsp_if.last;
				if (firing_q.size() == 0) begin
					report_mismatch("result with none expected, kind", 64'(got.kind), 'x);
				end else begin
					want = firing_q.pop_front();
					check_field("kind", 64'(got.kind), 64'(want.kind));
					check_field("fired_index", 64'(got.fired_index), 64'(want.fired_index));
					check_field("fired_param", 64'(got.fired_param), 64'(want.fired_param));
					check_field("fired_time", 64'(got.fired_time), 64'(want.fired_time));
					check_field("next_expiry", 64'(got.next_expiry), 64'(want.next_expiry));
					check_field("none_pending", 64'(got.none_pending),
						64'(want.none_pending));
					check_field("slice_length", 64'(got.slice_length),
						64'(want.slice_length));
					check_field("last", 64'(got.last), 64'(want.last));
				end
			end
			if (req_if.valid && req_if.ready) begin
				c.mode      = req_if.mode;
				c.idx       = req_if.timer_index;
				c.amount    = req_if.amount;
				c.never     = req_if.never_flag;
				c.from_fire = req_if.from_fire_time;
				c.param     = req_if.param;
				schedule_cmd(c);
			end
			if (cfg_if.valid && cfg_if.ready)
				slice_cap = cfg_if.data;
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("tb_multi_timer_expiry_scheduler_core: done, errors");
			$finish;
		end
	end

	// Result side: long hold-off first, then the per-item gap
	initial begin : receiver
		rsp_if.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (rsp_hold_left > 0) begin
				rsp_hold_left--;
				rsp_if.ready = 1'b0;
			end else if (rsp_gap_left > 0) begin
				rsp_gap_left--;
				rsp_if.ready = 1'b0;
			end else begin
				rsp_if.ready = 1'b1;
			end
		end
	end

	// Offer one item after a random gap and hold it until taken
	task automatic send_cmd(input timer_cmd_t c);
		int gap;
		gap = draw_gap(req_calm);
		repeat (gap) begin
			@(negedge clk);
			req_if.valid = 1'b0;
		end
		@(negedge clk);
		req_if.valid          = 1'b1;
		req_if.mode           = c.mode;
		req_if.timer_index    = c.idx;
		req_if.amount         = c.amount;
		req_if.never_flag     = c.never;
		req_if.from_fire_time = c.from_fire;
		req_if.param          = c.param;
		do @(posedge clk); while (!req_if.ready);
	endtask

	task automatic arm_timer(input int idx, input logic [AMOUNT_W-1:0] dur,
		input logic [PARAM_W-1:0] param, input bit from_fire);
		timer_cmd_t c;
		c.mode      = MODE_ARM;
		c.idx       = IDX_W'(idx);
		c.amount    = dur;
		c.never     = 1'b0;
		c.from_fire = from_fire;
		c.param     = param;
		send_cmd(c);
	endtask

	task automatic advance_time(input logic [AMOUNT_W-1:0] elapsed);
		timer_cmd_t c;
		c.mode      = MODE_ADVANCE;
		c.idx       = '0;
		c.amount    = elapsed;
		c.never     = 1'b0;
		c.from_fire = 1'b0;
		c.param     = '0;
		send_cmd(c);
	endtask

	// Drop valid, wait for every expected result, then let the block settle
	task automatic drain_results();
		@(negedge clk);
		req_if.valid = 1'b0;
		while (firing_q.size() != 0)
			@(posedge clk);
		repeat (2 * SCAN_CYCLES) @(posedge clk);
	endtask

	task automatic write_slice_cap(input logic [SLICE_W-1:0] value);
		@(negedge clk);
		cfg_if.valid = 1'b1;
		cfg_if.data  = value;
		do @(posedge clk); while (!cfg_if.ready);
		@(negedge clk);
		cfg_if.valid = 1'b0;
	endtask

	// Mostly arm/advance traffic that keeps timers firing, with some far expiries
	function automatic timer_cmd_t random_cmd();
		timer_cmd_t c;
		int         sel;
		c.mode      = ($urandom_range(0, 9) < 6) ? MODE_ARM : MODE_ADVANCE;
		c.idx       = IDX_W'($urandom_range(0, NUM_TIMERS - 1));
		c.never     = ($urandom_range(0, 9) == 0);
		c.from_fire = ($urandom_range(0, 3) == 0);
		c.param     = $urandom();
		sel         = $urandom_range(0, 19);
		if (c.mode == MODE_ARM) begin
			if (sel < 14)
				c.amount = $urandom_range(0, 400);
			else if (sel < 18)
				c.amount = $urandom_range(0, 3000000);
			else
				c.amount = $urandom();
		end else begin
			if (sel < 15)
				c.amount = $urandom_range(0, 250);
			else if (sel < 19)
				c.amount = $urandom_range(0, 2000000);
			else
				c.amount = $urandom();
		end
		return c;
	endfunction

	task automatic run_random(input int count);
		int n;
		for (n = 0; n < count; n++) begin
			if (n % 15 == 0) begin
				req_calm = ($urandom_range(0, 2) == 0);
				rsp_calm = ($urandom_range(0, 2) == 0);
			end
			send_cmd(random_cmd());
		end
		req_calm = 1'b0;
		rsp_calm = 1'b0;
	endtask

	// Empty table, zero duration, disarm, measuring from the last firing, full-range amounts
	task automatic test_directed_events();
		timer_cmd_t c;
		advance_time('0);
		arm_timer(0, '0, 32'h7FFF_FFFF, 1'b0);
		arm_timer(NUM_TIMERS - 1, '1, 32'h8000_0000, 1'b0);
		arm_timer(2, 3, 32'h0000_0001, 1'b0);
		c.mode      = MODE_ARM;
		c.idx       = IDX_W'(2);
		c.amount    = '1;
		c.never     = 1'b1;
		c.from_fire = 1'b1;
		c.param     = '1;
		send_cmd(c);
		advance_time('0);
		arm_timer(9, 5, 32'h5A5A_A5A5, 1'b1);
		advance_time(5);
		advance_time('1);
		drain_results();
	endtask

	// Every timer due at once: ties resolve by index, one item gives the most results
	task automatic test_tie_burst();
		int                  i;
		logic [AMOUNT_W-1:0] dur;
		dur = $urandom_range(1, 50);
		for (i = 0; i < NUM_TIMERS; i++)
			arm_timer(i, dur, $urandom(), 1'b0);
		advance_time(dur);
		drain_results();
	endtask

	// Hold the result side off while items keep coming
	task automatic test_backpressure();
		int round;
		int i;
		rsp_hold_left = 40 * SCAN_CYCLES;
		req_calm      = 1'b1;
		for (round = 0; round < 8; round++) begin
			for (i = 0; i < 3; i++)
				arm_timer($urandom_range(0, NUM_TIMERS - 1), $urandom_range(1, 3),
					$urandom(), 1'b0);
			advance_time(3);
		end
		req_calm = 1'b0;
		drain_results();
	endtask

	// Random traffic under a range of slice caps, extremes included
	task automatic test_slice_settings();
		logic [SLICE_W-1:0] caps [6];
		int                 k;
		caps[0] = '0;
		caps[1] = SLICE_W'(1);
		caps[2] = '1;
		caps[3] = SLICE_W'(1000000);
		caps[4] = SLICE_W'($urandom_range(2, 999999));
		caps[5] = SLICE_CAP_RESET;
		for (k = 0; k < 6; k++) begin
			write_slice_cap(caps[k]);
			run_random(PHASE_ITEMS);
			drain_results();
		end
	endtask

	initial begin
		arst_n                = 1'b0;
		req_if.valid          = 1'b0;
		req_if.mode           = MODE_ARM;
		req_if.timer_index    = '0;
		req_if.amount         = '0;
		req_if.never_flag     = 1'b0;
		req_if.from_fire_time = 1'b0;
		req_if.param          = '0;
		cfg_if.valid          = 1'b0;
		cfg_if.data           = '0;
		clear_schedule();
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n = 1'b1;

		test_directed_events();
		test_tie_burst();
		test_backpressure();
		test_slice_settings();
		drain_results();

		if (error_count == 0)
			$display("tb_multi_timer_expiry_scheduler_core: done, clean");
		else
			$display("tb_multi_timer_expiry_scheduler_core: done, errors");
		$finish;
	end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/mtes_pkg.sv
rtl/mtes_req_if.sv
rtl/mtes_rsp_if.sv
rtl/mtes_cfg_if.sv
rtl/mtes_cell.sv
rtl/mtes_ctrl.sv
rtl/multi_timer_expiry_scheduler_core.sv
rtl/mtes_checker.sv
test/tb_multi_timer_expiry_scheduler_core.sv
